[hdl/vcacd_pkg.sv]
// ----------------------------------------------------------------------------
// vcacd_pkg
// Shared types, register map and palette tables of the video cell decoder.
// ----------------------------------------------------------------------------
package vcacd_pkg;

  localparam int unsigned ROW_W    = 8;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned RGB_W    = 24;
  localparam int unsigned BANK_W   = 2;
  localparam int unsigned OFFS_W   = 14;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned PIXCNT_W = 3;

  // register select: paddr bit 2
  localparam logic REG_MACHINE_MODEL = 1'b0;
  localparam logic REG_IMAGE_SELECT  = 1'b1;

  localparam logic [OFFS_W-1:0] COLOR_BASE = 14'h2800;
  localparam logic [OFFS_W-1:0] STRIP_PIX  = 14'h2000;
  localparam logic [OFFS_W-1:0] STRIP_COL  = 14'h3000;

  typedef struct packed {
    logic [RGB_W-1:0]  fg;
    logic [RGB_W-1:0]  bg;
    logic [BYTE_W-1:0] pix;
    logic [BANK_W-1:0] pbank;
    logic [OFFS_W-1:0] poff;
    logic [BANK_W-1:0] cbank;
    logic [OFFS_W-1:0] coff;
  } cell_t;

  function automatic logic [RGB_W-1:0] fg_color(input logic [3:0] idx);
    logic [RGB_W-1:0] c;
    case (idx)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'hFF0000;
      4'd2:    c = 24'h0000FF;
      4'd3:    c = 24'hFF00FF;
      4'd4:    c = 24'h00FF00;
      4'd5:    c = 24'hFFFF00;
      4'd6:    c = 24'h00FFFF;
      4'd7:    c = 24'hFFFFFF;
      4'd8:    c = 24'h000000;
      4'd9:    c = 24'hFF00A0;
      4'd10:   c = 24'h00A0FF;
      4'd11:   c = 24'hA000FF;
      4'd12:   c = 24'hA0FF00;
      4'd13:   c = 24'hFFA000;
      4'd14:   c = 24'h00FFA0;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

  function automatic logic [RGB_W-1:0] bg_color(input logic [2:0] idx);
    logic [RGB_W-1:0] c;
    case (idx)
      3'd0:    c = 24'h000000;
      3'd1:    c = 24'hA00000;
      3'd2:    c = 24'h0000A0;
      3'd3:    c = 24'hA000A0;
      3'd4:    c = 24'h00A000;
      3'd5:    c = 24'hA0A000;
      3'd6:    c = 24'h00A0A0;
      default: c = 24'hA0A0A0;
    endcase
    return c;
  endfunction

endpackage

[hdl/vcacd_decode.sv]
// ----------------------------------------------------------------------------
// vcacd_decode
// Input stage and decode stage: bank/offset of the cell bytes, palette lookup.
// ----------------------------------------------------------------------------
module vcacd_decode (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [vcacd_pkg::ROW_W-1:0]         row_i,
  input  logic [vcacd_pkg::COL_W-1:0]         column_i,
  input  logic [vcacd_pkg::BYTE_W-1:0]        pixel_bits_i,
  input  logic [vcacd_pkg::BYTE_W-1:0]        color_bits_i,
  input  logic                                blink_active_i,
  input  logic                                machine_model_i,
  input  logic                                image_select_i,
  output logic                                cell_valid_o,
  input  logic                                cell_ready_i,
  output vcacd_pkg::cell_t                    cell_o
);

  logic                          v1_q, v2_q;
  logic                          s2_ready;
  logic [vcacd_pkg::ROW_W-1:0]   row_q;
  logic [vcacd_pkg::COL_W-1:0]   col_q;
  logic [vcacd_pkg::BYTE_W-1:0]  pix_q;
  logic [vcacd_pkg::BYTE_W-1:0]  cbits_q;
  logic                          blink_q;
  vcacd_pkg::cell_t              cell_d, cell_q;
  logic [vcacd_pkg::RGB_W-1:0]   bg;

  assign s2_ready   = !v2_q || cell_ready_i;
  assign in_ready_o = !v1_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v1_q <= in_valid_i;
      end
      if (s2_ready) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      row_q   <= row_i;
      col_q   <= column_i;
      pix_q   <= pixel_bits_i;
      cbits_q <= color_bits_i;
      blink_q <= blink_active_i;
    end
    if (s2_ready && v1_q) begin
      cell_q <= cell_d;
    end
  end

  // address and color decode
  always_comb begin
    bg        = vcacd_pkg::bg_color(cbits_q[2:0]);
    cell_d.bg = bg;
    cell_d.fg = (blink_q && cbits_q[7]) ? bg : vcacd_pkg::fg_color(cbits_q[6:3]);
    cell_d.pix = pix_q;
    if (machine_model_i) begin
      cell_d.pbank = {image_select_i, 1'b0};
      cell_d.cbank = {image_select_i, 1'b1};
      cell_d.poff  = {col_q, row_q};
      cell_d.coff  = {col_q, row_q};
    end else begin
      cell_d.pbank = '0;
      cell_d.cbank = '0;
      if (!col_q[5]) begin
        cell_d.poff = {1'b0, row_q[7:4], row_q[1:0], row_q[3:2], col_q[4:0]};
        cell_d.coff = vcacd_pkg::COLOR_BASE + {3'b000, row_q[7:2], col_q[4:0]};
      end else begin
        cell_d.poff = vcacd_pkg::STRIP_PIX
                    + {3'b000, row_q[7:6], row_q[1:0], row_q[3:2], row_q[5:4], col_q[2:0]};
        cell_d.coff = vcacd_pkg::STRIP_COL
                    + {5'b00000, row_q[7:6], row_q[3:2], row_q[5:4], col_q[2:0]};
      end
    end
  end

  assign cell_valid_o = v2_q;
  assign cell_o       = cell_q;

endmodule

[hdl/vcacd_serial.sv]
// ----------------------------------------------------------------------------
// vcacd_serial
// Pixel serializer: eight results per cell, leftmost first, registered out.
// ----------------------------------------------------------------------------
module vcacd_serial (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cell_valid_i,
  output logic                             cell_ready_o,
  input  vcacd_pkg::cell_t                 cell_i,
  output logic                             strobe_o,
  output logic [vcacd_pkg::RGB_W-1:0]      pixel_color_o,
  output logic [vcacd_pkg::BANK_W-1:0]     pixel_bank_o,
  output logic [vcacd_pkg::OFFS_W-1:0]     pixel_ofs_o,
  output logic [vcacd_pkg::BANK_W-1:0]     color_bank_o,
  output logic [vcacd_pkg::OFFS_W-1:0]     color_ofs_o,
  output logic                             last_pixel_o
);

  logic                               sv_q;
  logic [vcacd_pkg::PIXCNT_W-1:0]     cnt_q;
  vcacd_pkg::cell_t                   cur_q;
  logic                               last;
  logic                               load;
  logic                               strobe_q;
  logic [vcacd_pkg::RGB_W-1:0]        color_q;
  logic [vcacd_pkg::BANK_W-1:0]       pbank_q, cbank_q;
  logic [vcacd_pkg::OFFS_W-1:0]       poff_q, coff_q;
  logic                               last_q;

  assign last         = sv_q && (cnt_q == '1);
  assign cell_ready_o = !sv_q || last;
  assign load         = cell_valid_i && cell_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q     <= 1'b0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= sv_q;
      if (load) begin
        sv_q  <= 1'b1;
        cnt_q <= '0;
      end else if (sv_q) begin
        sv_q  <= !last;
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= cell_i;
    end else if (sv_q) begin
      cur_q.pix <= {cur_q.pix[vcacd_pkg::BYTE_W-2:0], 1'b0};
    end
    color_q <= cur_q.pix[vcacd_pkg::BYTE_W-1] ? cur_q.fg : cur_q.bg;
    pbank_q <= cur_q.pbank;
    poff_q  <= cur_q.poff;
    cbank_q <= cur_q.cbank;
    coff_q  <= cur_q.coff;
    last_q  <= last;
  end

  assign strobe_o      = strobe_q;
  assign pixel_color_o = color_q;
  assign pixel_bank_o  = pbank_q;
  assign pixel_ofs_o   = poff_q;
  assign color_bank_o  = cbank_q;
  assign color_ofs_o   = coff_q;
  assign last_pixel_o  = last_q;

endmodule

[hdl/video_cell_address_and_color_decoder.sv]
// ----------------------------------------------------------------------------
// video_cell_address_and_color_decoder
// Character cell decoder: memory bank/offset of the cell bytes and 8 colors.
// ----------------------------------------------------------------------------
// A cell request is taken when start is high and busy is low. It passes an
// input register and a decode register, then the serializer emits eight
// results on consecutive cycles, leftmost pixel first, each marked by
// strobe_o for one cycle; the receiver cannot stall. The serializer sets the
// rate: it takes the next cell while the current one is still being
// emitted, so a steady stream of requests gives an unbroken run of results.
// ----------------------------------------------------------------------------
module video_cell_address_and_color_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [vcacd_pkg::PADDR_W-1:0]    paddr,
  input  logic [vcacd_pkg::PDATA_W-1:0]    pwdata,
  output logic [vcacd_pkg::PDATA_W-1:0]    prdata,
  output logic                             pready,
  input  logic                             start,
  output logic                             busy,
  input  logic [vcacd_pkg::ROW_W-1:0]      row_i,
  input  logic [vcacd_pkg::COL_W-1:0]      column_i,
  input  logic [vcacd_pkg::BYTE_W-1:0]     pixel_bits_i,
  input  logic [vcacd_pkg::BYTE_W-1:0]     color_bits_i,
  input  logic                             blink_active_i,
  output logic                             strobe_o,
  output logic [vcacd_pkg::RGB_W-1:0]      pixel_color_o,
  output logic [vcacd_pkg::BANK_W-1:0]     pixel_bank_o,
  output logic [vcacd_pkg::OFFS_W-1:0]     pixel_ofs_o,
  output logic [vcacd_pkg::BANK_W-1:0]     color_bank_o,
  output logic [vcacd_pkg::OFFS_W-1:0]     color_ofs_o,
  output logic                             last_pixel_o
);

  logic             model_q, image_q;
  logic             wr_en;
  logic             in_ready;
  logic             cell_valid, cell_ready;
  vcacd_pkg::cell_t dec_cell;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= 1'b0;
      image_q <= 1'b0;
    end else if (wr_en) begin
      case (paddr[2])
        vcacd_pkg::REG_MACHINE_MODEL: model_q <= pwdata[0];
        vcacd_pkg::REG_IMAGE_SELECT:  image_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      vcacd_pkg::REG_MACHINE_MODEL: prdata = {{(vcacd_pkg::PDATA_W-1){1'b0}}, model_q};
      vcacd_pkg::REG_IMAGE_SELECT:  prdata = {{(vcacd_pkg::PDATA_W-1){1'b0}}, image_q};
      default:                      prdata = '0;
    endcase
  end

  assign busy = !in_ready;

  vcacd_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (start),
    .in_ready_o      (in_ready),
    .row_i           (row_i),
    .column_i        (column_i),
    .pixel_bits_i    (pixel_bits_i),
    .color_bits_i    (color_bits_i),
    .blink_active_i  (blink_active_i),
    .machine_model_i (model_q),
    .image_select_i  (image_q),
    .cell_valid_o    (cell_valid),
    .cell_ready_i    (cell_ready),
    .cell_o          (dec_cell)
  );

  vcacd_serial u_serial (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cell_valid_i  (cell_valid),
    .cell_ready_o  (cell_ready),
    .cell_i        (dec_cell),
    .strobe_o      (strobe_o),
    .pixel_color_o (pixel_color_o),
    .pixel_bank_o  (pixel_bank_o),
    .pixel_ofs_o   (pixel_ofs_o),
    .color_bank_o  (color_bank_o),
    .color_ofs_o   (color_ofs_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

[test/vcacd_cell_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vcacd_cell_checker
// Watches the register port, the cell requests and the pixel results of the
// video cell decoder. For every accepted request it predicts the eight pixel
// results, with their palette colors and memory addresses, and compares the
// strobed results in order, field by field.
// ----------------------------------------------------------------------------
module vcacd_cell_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [vcacd_pkg::PADDR_W-1:0]    paddr,
  input  logic [vcacd_pkg::PDATA_W-1:0]    pwdata,
  input  logic                             pready,
  input  logic                             start,
  input  logic                             busy,
  input  logic [vcacd_pkg::ROW_W-1:0]      row_i,
  input  logic [vcacd_pkg::COL_W-1:0]      column_i,
  input  logic [vcacd_pkg::BYTE_W-1:0]     pixel_bits_i,
  input  logic [vcacd_pkg::BYTE_W-1:0]     color_bits_i,
  input  logic                             blink_active_i,
  input  logic                             strobe_i,
  input  logic [vcacd_pkg::RGB_W-1:0]      pixel_color_i,
  input  logic [vcacd_pkg::BANK_W-1:0]     pixel_bank_i,
  input  logic [vcacd_pkg::OFFS_W-1:0]     pixel_ofs_i,
  input  logic [vcacd_pkg::BANK_W-1:0]     color_bank_i,
  input  logic [vcacd_pkg::OFFS_W-1:0]     color_ofs_i,
  input  logic                             last_pixel_i,
  output int                               pixels_pending_o,
  output int                               mismatch_count_o
);

  localparam logic [vcacd_pkg::OFFS_W-1:0] PIX_STRIP_BASE   = 14'h2000;
  localparam logic [vcacd_pkg::OFFS_W-1:0] COLOR_AREA_BASE  = 14'h2800;
  localparam logic [vcacd_pkg::OFFS_W-1:0] COLOR_STRIP_BASE = COLOR_AREA_BASE + 14'h0800;

  localparam logic [15:0][vcacd_pkg::RGB_W-1:0] FG_RGB = {
    24'hFFFFFF, 24'h00FFA0, 24'hFFA000, 24'hA0FF00,
    24'hA000FF, 24'h00A0FF, 24'hFF00A0, 24'h000000,
    24'hFFFFFF, 24'h00FFFF, 24'hFFFF00, 24'h00FF00,
    24'hFF00FF, 24'h0000FF, 24'hFF0000, 24'h000000
  };

  localparam logic [7:0][vcacd_pkg::RGB_W-1:0] BG_RGB = {
    24'hA0A0A0, 24'h00A0A0, 24'hA0A000, 24'h00A000,
    24'hA000A0, 24'h0000A0, 24'hA00000, 24'h000000
  };

  typedef struct packed {
    logic [vcacd_pkg::RGB_W-1:0]  rgb;
    logic [vcacd_pkg::BANK_W-1:0] pbank;
    logic [vcacd_pkg::OFFS_W-1:0] poff;
    logic [vcacd_pkg::BANK_W-1:0] cbank;
    logic [vcacd_pkg::OFFS_W-1:0] coff;
    logic                         last;
  } pixel_res_t;

  logic       linear_layout = 1'b0;
  logic       shown_image   = 1'b0;
  int         mismatches    = 0;
  pixel_res_t pixel_exp_q[$];

  assign mismatch_count_o = mismatches;

  function automatic pixel_res_t cell_pixel(input logic model, input logic img,
                                            input logic [vcacd_pkg::ROW_W-1:0] r,
                                            input logic [vcacd_pkg::COL_W-1:0] c,
                                            input logic [vcacd_pkg::BYTE_W-1:0] p,
                                            input logic [vcacd_pkg::BYTE_W-1:0] cb,
                                            input logic bl, input int k);
    pixel_res_t                  res;
    logic [vcacd_pkg::RGB_W-1:0] bg;
    logic [vcacd_pkg::RGB_W-1:0] fg;
    if (model) begin
      res.pbank = {img, 1'b0};
      res.cbank = {img, 1'b1};
      res.poff  = {c, r};
      res.coff  = {c, r};
    end else begin
      res.pbank = '0;
      res.cbank = '0;
      if (c < 6'd32) begin
        res.poff = 14'({r[7:4], r[1:0], r[3:2], c[4:0]});
        res.coff = COLOR_AREA_BASE + 14'({r[7:2], c[4:0]});
      end else begin
        res.poff = PIX_STRIP_BASE + 14'({r[7:6], r[1:0], r[3:2], r[5:4], c[2:0]});
        res.coff = COLOR_STRIP_BASE + 14'({r[7:6], r[3:2], r[5:4], c[2:0]});
      end
    end
    bg = BG_RGB[cb[2:0]];
    fg = (bl && cb[7]) ? bg : FG_RGB[cb[6:3]];
    res.rgb  = p[7-k] ? fg : bg;
    res.last = (k == 7);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [vcacd_pkg::RGB_W-1:0] want,
                             input logic [vcacd_pkg::RGB_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_res_t want;
    if (!rst_ni) begin
      linear_layout = 1'b0;
      shown_image   = 1'b0;
      pixel_exp_q.delete();
      pixels_pending_o <= 0;
    end else begin
      if (strobe_i) begin
        if (pixel_exp_q.size() == 0) begin
          $error("pixel result with no request outstanding");
          mismatches++;
        end else begin
          want = pixel_exp_q.pop_front();
          check_field("pixel_color", want.rgb, pixel_color_i);
          check_field("pixel_bank", 24'(want.pbank), 24'(pixel_bank_i));
          check_field("pixel_ofs", 24'(want.poff), 24'(pixel_ofs_i));
          check_field("color_bank", 24'(want.cbank), 24'(color_bank_i));
          check_field("color_ofs", 24'(want.coff), 24'(color_ofs_i));
          check_field("last_pixel", 24'(want.last), 24'(last_pixel_i));
        end
      end
      if (start && !busy) begin
        for (int k = 0; k < 8; k++) begin
          pixel_exp_q.push_back(cell_pixel(linear_layout, shown_image, row_i, column_i,
                                           pixel_bits_i, color_bits_i, blink_active_i, k));
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == vcacd_pkg::REG_MACHINE_MODEL) begin
          linear_layout = pwdata[0];
        end else begin
          shown_image = pwdata[0];
        end
      end
      pixels_pending_o <= pixel_exp_q.size();
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the video cell decoder. Sets both layout registers through the
// register port in several combinations, sends directed corner cells and then
// random cells with random gaps (none in one phase), and reports the checker verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int          RESET_CYCLES = 11;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          CELLS_PER_PHASE = 25;
  localparam logic [3:0]  MODEL_SEQ = 4'b0110;
  localparam logic [3:0]  IMAGE_SEQ = 4'b1100;
  localparam logic [5:0][vcacd_pkg::COL_W-1:0] CORNER_COLS = {
    6'd63, 6'd40, 6'd39, 6'd32, 6'd31, 6'd0
  };

  logic                             clk_i          = 1'b0;
  logic                             rst_ni         = 1'b0;
  logic                             psel           = 1'b0;
  logic                             penable        = 1'b0;
  logic                             pwrite         = 1'b0;
  logic [vcacd_pkg::PADDR_W-1:0]    paddr          = '0;
  logic [vcacd_pkg::PDATA_W-1:0]    pwdata         = '0;
  logic [vcacd_pkg::PDATA_W-1:0]    prdata;
  logic                             pready;
  logic                             start          = 1'b0;
  logic                             busy;
  logic [vcacd_pkg::ROW_W-1:0]      row_i          = '0;
  logic [vcacd_pkg::COL_W-1:0]      column_i       = '0;
  logic [vcacd_pkg::BYTE_W-1:0]     pixel_bits_i   = '0;
  logic [vcacd_pkg::BYTE_W-1:0]     color_bits_i   = '0;
  logic                             blink_active_i = 1'b0;
  logic                             strobe_o;
  logic [vcacd_pkg::RGB_W-1:0]      pixel_color_o;
  logic [vcacd_pkg::BANK_W-1:0]     pixel_bank_o;
  logic [vcacd_pkg::OFFS_W-1:0]     pixel_ofs_o;
  logic [vcacd_pkg::BANK_W-1:0]     color_bank_o;
  logic [vcacd_pkg::OFFS_W-1:0]     color_ofs_o;
  logic                             last_pixel_o;
  int                               pixels_pending;
  int                               mismatch_count;
  logic                             gaps_on = 1'b1;

  video_cell_address_and_color_decoder dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .row_i, .column_i, .pixel_bits_i, .color_bits_i,
    .blink_active_i, .strobe_o, .pixel_color_o, .pixel_bank_o, .pixel_ofs_o,
    .color_bank_o, .color_ofs_o, .last_pixel_o
  );

  vcacd_cell_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .start, .busy, .row_i, .column_i, .pixel_bits_i, .color_bits_i,
    .blink_active_i,
    .strobe_i         (strobe_o),
    .pixel_color_i    (pixel_color_o),
    .pixel_bank_i     (pixel_bank_o),
    .pixel_ofs_i      (pixel_ofs_o),
    .color_bank_i     (color_bank_o),
    .color_ofs_i      (color_ofs_o),
    .last_pixel_i     (last_pixel_o),
    .pixels_pending_o (pixels_pending),
    .mismatch_count_o (mismatch_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #500000;
    $display("FAIL");
    $finish;
  end

  // one cell request, held until taken
  task automatic send_cell(input logic [vcacd_pkg::ROW_W-1:0] r,
                           input logic [vcacd_pkg::COL_W-1:0] c,
                           input logic [vcacd_pkg::BYTE_W-1:0] p,
                           input logic [vcacd_pkg::BYTE_W-1:0] cb,
                           input logic bl);
    if (gaps_on) begin
      while ($urandom_range(99) < 35) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start          <= 1'b1;
    row_i          <= r;
    column_i       <= c;
    pixel_bits_i   <= p;
    color_bits_i   <= cb;
    blink_active_i <= bl;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain_pixels();
    start <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pixels_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic sel, input logic v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_cell();
    logic [vcacd_pkg::COL_W-1:0] c;
    c = ($urandom_range(99) < 75) ? vcacd_pkg::COL_W'($urandom_range(39))
                                  : vcacd_pkg::COL_W'($urandom_range(63, 40));
    send_cell(8'($urandom_range(255)), c, 8'($urandom_range(255)),
              8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  initial begin
    logic [vcacd_pkg::BYTE_W-1:0] cb;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(vcacd_pkg::REG_MACHINE_MODEL, MODEL_SEQ[ph]);
      write_reg(vcacd_pkg::REG_IMAGE_SELECT, IMAGE_SEQ[ph]);
      gaps_on = (ph != 2);

      if (ph == 0) begin
        // every foreground index, blink enable/flag combinations, corner columns
        for (int i = 0; i < 16; i++) begin
          cb = {i[0], i[3:0], i[2:0]};
          send_cell((i < 4) ? (i[0] ? 8'd255 : 8'd0) : 8'($urandom_range(255)),
                    (i < 6) ? CORNER_COLS[i] : vcacd_pkg::COL_W'($urandom_range(63)),
                    (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(255)),
                    cb, i[1]);
        end
      end else if (ph == 1) begin
        send_cell(8'd255, 6'd63, 8'hA5, 8'hFF, 1'b1);
        send_cell(8'd0, 6'd0, 8'h5A, 8'h00, 1'b0);
        send_cell(8'd128, 6'd39, 8'hF0, 8'h7F, 1'b0);
        send_cell(8'd1, 6'd40, 8'h0F, 8'h80, 1'b1);
      end

      for (int n = 0; n < CELLS_PER_PHASE; n++) begin
        send_random_cell();
      end
      drain_pixels();
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hdl/vcacd_pkg.sv
hdl/vcacd_decode.sv
hdl/vcacd_serial.sv
hdl/video_cell_address_and_color_decoder.sv
test/vcacd_cell_checker.sv
test/tb.sv
